/* src/pct_pkg.sv */
// shared types and constants for the presence confidence tracker
`timescale 1ns / 1ps

package pct_pkg;

  // confidence format, Q1.16
  localparam int CONF_W = 17;
  localparam logic [CONF_W-1:0] Q_ONE = 17'd65536;

  // presence states
  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] ST_NONE        = 3'd0;
  localparam logic [STATE_W-1:0] ST_COUNT_IN    = 3'd1;
  localparam logic [STATE_W-1:0] ST_FOUND_FIRST = 3'd2;
  localparam logic [STATE_W-1:0] ST_FOUND       = 3'd3;
  localparam logic [STATE_W-1:0] ST_COUNT_OUT   = 3'd4;

  // item opcodes
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_UPDATE     = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR_MARK = 2'd1;
  localparam logic [OP_W-1:0] OP_RESET_CNT  = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_RATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADD_AMOUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_STOP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEE_TIME    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FORGET_TIME = 3'd5;

  // configuration reset values
  localparam logic [15:0] FADE_RATE_RST   = 16'd62259;
  localparam logic [16:0] ADD_AMOUNT_RST  = 17'd6554;
  localparam logic [16:0] GATE_START_RST  = 17'd42598;
  localparam logic [16:0] GATE_STOP_RST   = 17'd26214;
  localparam logic [31:0] SEE_TIME_RST    = 32'd1000;
  localparam logic [31:0] FORGET_TIME_RST = 32'd1000;

  // active configuration
  typedef struct packed {
    logic [15:0] fade_rate;
    logic [16:0] add_amount;
    logic [16:0] gate_start;
    logic [16:0] gate_stop;
    logic [31:0] see_time_ms;
    logic [31:0] forget_time_ms;
  } pct_cfg_t;

  // one result item
  typedef struct packed {
    logic [CONF_W-1:0]  confidence_level;
    logic               first_seen;
    logic               seeing_face;
    logic [STATE_W-1:0] face_state;
  } pct_res_t;

endpackage

/* src/pct_cfg.sv */
// configuration register file for the presence confidence tracker
`timescale 1ns / 1ps

module pct_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [pct_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [pct_pkg::CFG_DATA_W-1:0] wr_data,
  output pct_pkg::pct_cfg_t         cfg
);
  import pct_pkg::*;

  // register writes by index, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fade_rate      <= FADE_RATE_RST;
      cfg.add_amount     <= ADD_AMOUNT_RST;
      cfg.gate_start     <= GATE_START_RST;
      cfg.gate_stop      <= GATE_STOP_RST;
      cfg.see_time_ms    <= SEE_TIME_RST;
      cfg.forget_time_ms <= FORGET_TIME_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_FADE_RATE:   cfg.fade_rate      <= wr_data[15:0];
        REG_ADD_AMOUNT:  cfg.add_amount     <= wr_data[16:0];
        REG_GATE_START:  cfg.gate_start     <= wr_data[16:0];
        REG_GATE_STOP:   cfg.gate_stop      <= wr_data[16:0];
        REG_SEE_TIME:    cfg.see_time_ms    <= wr_data;
        REG_FORGET_TIME: cfg.forget_time_ms <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

/* src/pct_core.sv */
// confidence decay, hysteresis gates and presence state machine
`timescale 1ns / 1ps

module pct_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [pct_pkg::OP_W-1:0]    opcode,
  input  logic                        face_detected,
  input  logic [31:0]                 now_ms,
  input  pct_pkg::pct_cfg_t           cfg,
  output pct_pkg::pct_res_t           res
);
  import pct_pkg::*;

  logic [CONF_W-1:0]  conf;
  logic [CONF_W-1:0]  conf_next;
  logic [STATE_W-1:0] state;
  logic [STATE_W-1:0] state_next;
  logic [31:0]        look_start;
  logic [31:0]        look_start_next;
  logic [31:0]        forget_start;
  logic [31:0]        forget_start_next;

  logic [32:0]        prod;
  logic [CONF_W-1:0]  decayed;
  logic [CONF_W:0]    sum;
  logic [CONF_W:0]    c;
  logic               ge_start;
  logic               le_stop;
  logic [31:0]        look_elapsed;
  logic [31:0]        forget_elapsed;

  // decay, optional add, clamp to one
  always_comb begin
    prod    = {16'd0, conf} * {17'd0, cfg.fade_rate};
    decayed = prod[32:16];
    sum     = {1'b0, decayed} + {1'b0, cfg.add_amount};
    if (face_detected) begin
      c = (sum > {1'b0, Q_ONE}) ? {1'b0, Q_ONE} : sum;
    end else begin
      c = {1'b0, decayed};
    end
    ge_start       = c >= {1'b0, cfg.gate_start};
    le_stop        = c <= {1'b0, cfg.gate_stop};
    look_elapsed   = now_ms - look_start;
    forget_elapsed = now_ms - forget_start;
  end

  // next state per opcode
  always_comb begin
    conf_next         = conf;
    state_next        = state;
    look_start_next   = look_start;
    forget_start_next = forget_start;
    case (opcode)
      OP_UPDATE: begin
        conf_next = c[CONF_W-1:0];
        if (ge_start) begin
          case (state)
            ST_NONE: begin
              look_start_next = now_ms;
              state_next      = ST_COUNT_IN;
            end
            ST_COUNT_OUT: state_next = ST_FOUND;
            ST_COUNT_IN: begin
              if (look_elapsed > cfg.see_time_ms) state_next = ST_FOUND_FIRST;
            end
            ST_FOUND_FIRST: state_next = ST_FOUND;
            default: ;
          endcase
        end else if (le_stop) begin
          case (state)
            ST_FOUND, ST_FOUND_FIRST: begin
              forget_start_next = now_ms;
              state_next        = ST_COUNT_OUT;
            end
            ST_COUNT_IN: state_next = ST_NONE;
            ST_COUNT_OUT: begin
              if (forget_elapsed > cfg.forget_time_ms) state_next = ST_NONE;
            end
            default: ;
          endcase
        end
      end
      OP_CLEAR_MARK: begin
        if (state == ST_FOUND_FIRST) state_next = ST_FOUND;
      end
      OP_RESET_CNT: begin
        conf_next         = '0;
        state_next        = ST_NONE;
        look_start_next   = now_ms;
        forget_start_next = now_ms;
      end
      default: ;
    endcase
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      conf         <= '0;
      state        <= ST_NONE;
      look_start   <= '0;
      forget_start <= '0;
    end else if (en) begin
      conf         <= conf_next;
      state        <= state_next;
      look_start   <= look_start_next;
      forget_start <= forget_start_next;
    end
  end

  // result from the state after this item
  assign res.face_state       = state_next;
  assign res.seeing_face      = (state_next == ST_FOUND_FIRST) || (state_next == ST_FOUND);
  assign res.first_seen       = state_next == ST_FOUND_FIRST;
  assign res.confidence_level = conf_next;

  // confidence never rises above one
  assert property (@(posedge clk) disable iff (rst) conf <= Q_ONE)
    else $error("confidence above one");

  // reset counters clears confidence and state
  assert property (@(posedge clk) disable iff (rst)
    (en && opcode == OP_RESET_CNT) |=> (conf == '0 && state == ST_NONE))
    else $error("reset counters did not clear state");

  // found first is entered only from counting in
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FOUND_FIRST) |->
      ($past(state) == ST_COUNT_IN || $past(state) == ST_FOUND_FIRST))
    else $error("found first entered from wrong state");

  // state only moves when an item is processed
  assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(state) && $stable(conf))
    else $error("state changed without an item");

endmodule

/* src/presence_confidence_tracker.sv */
// top level: item input register, tracker core and result register
// an item passes the input register and then the result register before its result is valid
// throughput: one item per cycle while the result side accepts; the update, gate and state decision are combinational
// the decay multiply (17 x 16 bits) and gate compares set the critical path
// reset (rst, synchronous, active high) empties both registers, restores the
// default configuration and clears confidence, state and start times
`timescale 1ns / 1ps

module presence_confidence_tracker (
  input  logic        clk,
  input  logic        rst,
  // item input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // face_detected[0], now_ms[32:1], zero pad
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // face_state[2:0], seeing_face[3], first_seen[4],
                                      // confidence_level[21:5], zero pad
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [pct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pct_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pct_pkg::*;

  pct_cfg_t         cfg;
  pct_res_t         res;
  pct_res_t         res_q;

  logic             in_v;
  logic [OP_W-1:0]  in_op;
  logic             in_det;
  logic [31:0]      in_now;
  logic             out_v;
  logic             advance;

  assign cfg_ready = 1'b1;

  pct_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // item moves to the result register when that register is free or drains
  assign advance       = in_v && (!out_v || m_axis_tready);
  assign s_axis_tready = !in_v || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_axis_tready) begin
      in_v <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op  <= s_axis_tuser;
      in_det <= s_axis_tdata[0];
      in_now <= s_axis_tdata[32:1];
    end
  end

  pct_core u_core (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .opcode        (in_op),
    .face_detected (in_det),
    .now_ms        (in_now),
    .cfg           (cfg),
    .res           (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (advance) begin
      out_v <= 1'b1;
    end else if (m_axis_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {2'b00, res_q};

  // a processed item always shows up as a result next cycle
  assert property (@(posedge clk) disable iff (rst) advance |=> m_axis_tvalid)
    else $error("processed item lost");

endmodule

/* test/presence_confidence_tracker_tb.sv */
// testbench for the presence confidence tracker: directed rows, then random item runs
`timescale 1ns / 1ps

module presence_confidence_tracker_tb;
  import pct_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 212;
  localparam int NUM_PHASES = 8;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // one directed row: an item, optionally with a typed-in result, or a register write
  typedef struct {
    row_kind_e              kind;
    logic [OP_W-1:0]        op;
    logic                   det;
    logic [31:0]            now_ms;
    bit                     typed;
    logic [STATE_W-1:0]     st;
    logic [CONF_W-1:0]      conf;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
  } step_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [39:0]            s_axis_tdata;
  logic [1:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [23:0]            m_axis_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // tracker state as the testbench sees it
  pct_cfg_t               trk_cfg;
  logic [CONF_W-1:0]      conf_acc;
  logic [STATE_W-1:0]     presence;
  logic [31:0]            look_ms;
  logic [31:0]            forget_ms;

  pct_res_t               pending_results[$];
  step_row_t              plan[$];
  int                     fail_count = 0;
  int                     quiet_cycles = 0;
  int                     src_idle_pct = 0;
  int                     snk_stall_pct = 0;

  presence_confidence_tracker dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result output flags follow from the presence state
  function automatic pct_res_t status_of(input logic [STATE_W-1:0] st,
                                         input logic [CONF_W-1:0] conf);
    pct_res_t res;
    res.face_state       = st;
    res.seeing_face      = (st == ST_FOUND_FIRST) || (st == ST_FOUND);
    res.first_seen       = (st == ST_FOUND_FIRST);
    res.confidence_level = conf;
    return res;
  endfunction

  // advance the tracker by one item and return its result
  function automatic pct_res_t track_presence(input logic [OP_W-1:0] op, input logic det,
                                              input logic [31:0] now_ms);
    logic [32:0] prod;
    logic [17:0] level;
    logic [31:0] elapsed;
    case (op)
      OP_UPDATE: begin
        // decay, then add on detection and clamp to one
        prod  = {16'd0, conf_acc} * {17'd0, trk_cfg.fade_rate};
        level = {1'b0, prod[32:16]};
        if (det) begin
          level = level + {1'b0, trk_cfg.add_amount};
          if (level > {1'b0, Q_ONE}) level = {1'b0, Q_ONE};
        end
        conf_acc = level[CONF_W-1:0];
        // upper gate is tested first
        if (level >= {1'b0, trk_cfg.gate_start}) begin
          case (presence)
            ST_NONE: begin
              look_ms  = now_ms;
              presence = ST_COUNT_IN;
            end
            ST_COUNT_OUT: presence = ST_FOUND;
            ST_COUNT_IN: begin
              elapsed = now_ms - look_ms;
              if (elapsed > trk_cfg.see_time_ms) presence = ST_FOUND_FIRST;
            end
            ST_FOUND_FIRST: presence = ST_FOUND;
            default: ;
          endcase
        end else if (level <= {1'b0, trk_cfg.gate_stop}) begin
          case (presence)
            ST_FOUND, ST_FOUND_FIRST: begin
              forget_ms = now_ms;
              presence  = ST_COUNT_OUT;
            end
            ST_COUNT_IN: presence = ST_NONE;
            ST_COUNT_OUT: begin
              elapsed = now_ms - forget_ms;
              if (elapsed > trk_cfg.forget_time_ms) presence = ST_NONE;
            end
            default: ;
          endcase
        end
      end
      OP_CLEAR_MARK: begin
        if (presence == ST_FOUND_FIRST) presence = ST_FOUND;
      end
      OP_RESET_CNT: begin
        conf_acc  = '0;
        presence  = ST_NONE;
        look_ms   = now_ms;
        forget_ms = now_ms;
      end
      default: ;
    endcase
    return status_of(presence, conf_acc);
  endfunction

  function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_FADE_RATE:   trk_cfg.fade_rate      = val[15:0];
      REG_ADD_AMOUNT:  trk_cfg.add_amount     = val[16:0];
      REG_GATE_START:  trk_cfg.gate_start     = val[16:0];
      REG_GATE_STOP:   trk_cfg.gate_stop      = val[16:0];
      REG_SEE_TIME:    trk_cfg.see_time_ms    = val;
      REG_FORGET_TIME: trk_cfg.forget_time_ms = val;
      default: ;
    endcase
  endfunction

  // directed row builders
  function automatic void add_item(input logic [OP_W-1:0] op, input logic det,
                                   input logic [31:0] now_ms);
    step_row_t row;
    row = '{ROW_ITEM, op, det, now_ms, 1'b0, '0, '0, '0, '0};
    plan.push_back(row);
  endfunction

  function automatic void add_typed(input logic [OP_W-1:0] op, input logic det,
                                    input logic [31:0] now_ms, input logic [STATE_W-1:0] st,
                                    input logic [CONF_W-1:0] conf);
    step_row_t row;
    row = '{ROW_ITEM, op, det, now_ms, 1'b1, st, conf, '0, '0};
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    step_row_t row;
    row = '{ROW_CFG, OP_UPDATE, 1'b0, '0, 1'b0, '0, '0, idx, data};
    plan.push_back(row);
  endfunction

  // mostly a value from the middle band, sometimes one of the extremes
  function automatic logic [31:0] pick_value(input logic [31:0] lo_val, input logic [31:0] hi_val,
                                             input logic [31:0] mid_lo, input logic [31:0] mid_hi);
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return lo_val;
    if (roll < 20) return hi_val;
    return $urandom_range(mid_hi, mid_lo);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  // present one item and log its result once it is taken
  task automatic send_item(input logic [OP_W-1:0] op, input logic det, input logic [31:0] now_ms,
                           input bit typed, input pct_res_t typed_res);
    pct_res_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {7'd0, now_ms, det};
    do @(posedge clk); while (!s_axis_tready);
    res = track_presence(op, det, now_ms);
    pending_results.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  // hold off items until every result is out and the pipeline is empty
  task automatic drain;
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // result side back-pressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready = ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // compare each result with the oldest outstanding prediction
  always @(posedge clk) begin : check_results
    pct_res_t got;
    pct_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = pct_res_t'(m_axis_tdata[21:0]);
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("face_state", 32'(want.face_state), 32'(got.face_state));
        check_field("seeing_face", 32'(want.seeing_face), 32'(got.seeing_face));
        check_field("first_seen", 32'(want.first_seen), 32'(got.first_seen));
        check_field("confidence_level", 32'(want.confidence_level),
                    32'(got.confidence_level));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int          run_left;
    int          det_bias;
    int          roll;
    logic [31:0] clock_ms;
    logic [OP_W-1:0] op;
    logic [15:0] fade;
    logic [16:0] add;
    logic [16:0] g_start;
    logic [16:0] g_stop;
    logic [31:0] see_t;
    logic [31:0] forget_t;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;

    trk_cfg.fade_rate      = FADE_RATE_RST;
    trk_cfg.add_amount     = ADD_AMOUNT_RST;
    trk_cfg.gate_start     = GATE_START_RST;
    trk_cfg.gate_stop      = GATE_STOP_RST;
    trk_cfg.see_time_ms    = SEE_TIME_RST;
    trk_cfg.forget_time_ms = FORGET_TIME_RST;
    conf_acc  = '0;
    presence  = ST_NONE;
    look_ms   = '0;
    forget_ms = '0;

    // directed rows
    add_typed(OP_UPDATE, 1'b0, 32'd0, ST_NONE, '0);
    add_typed(OP_CLEAR_MARK, 1'b1, 32'd3, ST_NONE, '0);
    add_cfg(REG_ADD_AMOUNT, 32'(Q_ONE));
    add_typed(OP_UPDATE, 1'b1, 32'd100, ST_COUNT_IN, Q_ONE);
    // see dwell: equal to the limit does not count
    add_typed(OP_UPDATE, 1'b1, 32'd1100, ST_COUNT_IN, Q_ONE);
    add_typed(OP_UPDATE, 1'b1, 32'd1101, ST_FOUND_FIRST, Q_ONE);
    add_typed(OP_CLEAR_MARK, 1'b0, 32'd1200, ST_FOUND, Q_ONE);
    add_item(OP_UPDATE, 1'b0, 32'd2000);
    add_cfg(REG_FADE_RATE, 32'd0);
    add_typed(OP_UPDATE, 1'b0, 32'd3000, ST_COUNT_OUT, '0);
    add_typed(OP_UPDATE, 1'b1, 32'd3500, ST_FOUND, Q_ONE);
    add_typed(OP_UPDATE, 1'b0, 32'd4000, ST_COUNT_OUT, '0);
    add_typed(OP_UPDATE, 1'b0, 32'd5000, ST_COUNT_OUT, '0);
    add_typed(OP_UPDATE, 1'b0, 32'd5001, ST_NONE, '0);
    add_typed(OP_UPDATE, 1'b1, 32'd6000, ST_COUNT_IN, Q_ONE);
    add_typed(OP_UPDATE, 1'b0, 32'd6001, ST_NONE, '0);
    // timestamp wrap during counting in
    add_typed(OP_RESET_CNT, 1'b0, 32'hFFFF_FF00, ST_NONE, '0);
    add_typed(OP_UPDATE, 1'b1, 32'hFFFF_FFF0, ST_COUNT_IN, Q_ONE);
    add_typed(OP_UPDATE, 1'b1, 32'd1001, ST_FOUND_FIRST, Q_ONE);
    add_typed(OP_UNUSED, 1'b1, 32'd0, ST_FOUND_FIRST, Q_ONE);
    add_typed(OP_UPDATE, 1'b0, 32'h0000_0400, ST_COUNT_OUT, '0);
    // equal gates at one: upper gate wins
    add_cfg(REG_GATE_STOP, 32'(Q_ONE));
    add_cfg(REG_GATE_START, 32'(Q_ONE));
    add_typed(OP_UPDATE, 1'b1, 32'h0000_0500, ST_FOUND, Q_ONE);
    add_typed(OP_UPDATE, 1'b0, 32'h0000_0600, ST_COUNT_OUT, '0);
    add_cfg(REG_FORGET_TIME, 32'd0);
    add_typed(OP_UPDATE, 1'b0, 32'h0000_0600, ST_COUNT_OUT, '0);
    add_typed(OP_UPDATE, 1'b0, 32'h0000_0601, ST_NONE, '0);
    add_cfg(REG_SEE_TIME, 32'd0);
    add_typed(OP_UPDATE, 1'b1, 32'hFFFF_FFFF, ST_COUNT_IN, Q_ONE);
    add_typed(OP_UPDATE, 1'b1, 32'd0, ST_FOUND_FIRST, Q_ONE);
    add_typed(OP_RESET_CNT, 1'b1, 32'h1234_5678, ST_NONE, '0);

    // reset
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_item(plan[i].op, plan[i].det, plan[i].now_ms, plan[i].typed,
                  status_of(plan[i].st, plan[i].conf));
      end
    end

    // random phases, each with new settings and one of four idling patterns
    run_left = 0;
    det_bias = 50;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case (phase % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 82; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 82; end
        default: begin src_idle_pct = 22; snk_stall_pct = 22; end
      endcase
      case (phase)
        1: begin
          fade = 16'hFFFF; add = Q_ONE; g_start = Q_ONE; g_stop = Q_ONE;
          see_t = 32'hFFFF_FFFF; forget_t = 32'hFFFF_FFFF;
        end
        2: begin
          fade = '0; add = '0; g_start = '0; g_stop = '0; see_t = '0; forget_t = '0;
        end
        default: begin
          fade     = 16'(pick_value(0, 65535, 50000, 65535));
          add      = 17'(pick_value(0, 32'(Q_ONE), 2000, 20000));
          g_start  = 17'(pick_value(0, 32'(Q_ONE), 30000, 60000));
          g_stop   = 17'(pick_value(0, 32'(Q_ONE), 5000, 30000));
          see_t    = pick_value(0, 32'hFFFF_FFFF, 0, 600);
          forget_t = pick_value(0, 32'hFFFF_FFFF, 0, 600);
        end
      endcase
      write_reg(REG_FADE_RATE, {16'd0, fade});
      write_reg(REG_ADD_AMOUNT, {15'd0, add});
      write_reg(REG_GATE_START, {15'd0, g_start});
      write_reg(REG_GATE_STOP, {15'd0, g_stop});
      write_reg(REG_SEE_TIME, see_t);
      write_reg(REG_FORGET_TIME, forget_t);

      clock_ms = $urandom();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // runs of mostly-present or mostly-absent detections drive the hysteresis
        if (run_left == 0) begin
          run_left = $urandom_range(40, 3);
          det_bias = $urandom_range(1) ? 90 : 10;
        end
        run_left--;
        roll = $urandom_range(99);
        if (roll < 88)      op = OP_UPDATE;
        else if (roll < 93) op = OP_CLEAR_MARK;
        else if (roll < 97) op = OP_RESET_CNT;
        else                op = OP_UNUSED;
        if ($urandom_range(99) < 2) clock_ms = $urandom();
        else clock_ms = clock_ms + $urandom_range(60);
        send_item(op, $urandom_range(99) < det_bias, clock_ms, 1'b0, '0);
      end
    end

    // let the last results come out
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
